// ===== src/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants of the image signature scanner.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Offset counter width; match_offset carries the low 24 bits.
  localparam int OffsetWidth = 24;
  localparam int ResOffWidth = 24;

  localparam int WinLen  = 12;
  localparam int HistLen = WinLen - 1;
  localparam int PosWidth = $clog2(WinLen);

  localparam logic [OffsetWidth-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    FmtNone = 2'd0,
    FmtJpeg = 2'd1,
    FmtJp2  = 2'd2
  } fmt_e;

  // hist[0] is the newest byte
  typedef logic [HistLen-1:0][7:0] hist_t;

  typedef struct packed {
    logic                   hit;
    fmt_e                   fmt;
    logic [OffsetWidth-1:0] offset;
  } match_t;

  localparam logic [7:0] SigJpeg [3] = '{8'hFF, 8'hD8, 8'hFF};
  localparam logic [7:0] SigJp2 [12] = '{8'h00, 8'h00, 8'h00, 8'h0C, 8'h6A, 8'h50,
                                         8'h20, 8'h20, 8'h0D, 8'h0A, 8'h87, 8'h0A};
  localparam logic [7:0] SigJ2k [4]  = '{8'hFF, 8'h4F, 8'hFF, 8'h51};

endpackage

// ===== src/isc_stream_if.sv =====
// ----------------------------------------------------------------------------
// isc_stream_if
// Valid/ready channels of the scanner: byte words in, result words out.
// ----------------------------------------------------------------------------
interface isc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface isc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  image_format;
  logic [23:0] match_offset;
  logic        count_overflow;

  modport source (output valid, output found, output image_format,
                  output match_offset, output count_overflow, input ready);
  modport sink (input valid, input found, input image_format,
                input match_offset, input count_overflow, output ready);
endinterface

// ===== src/isc_history.sv =====
// ----------------------------------------------------------------------------
// isc_history
// Shift line of the eleven bytes before the current one, newest first.
// ----------------------------------------------------------------------------
module isc_history
  import isc_pkg::*;
(
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output hist_t      hist_o
);

  hist_t hist_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      hist_q <= {hist_q[HistLen-2:0], byte_i};
    end
  end

  assign hist_o = hist_q;

endmodule

// ===== src/isc_window_match.sv =====
// ----------------------------------------------------------------------------
// isc_window_match
// Compares the 12-byte window against the three signatures at each start
// position where they fit and picks the earliest one that is allowed.
// ----------------------------------------------------------------------------
module isc_window_match
  import isc_pkg::*;
(
  input  hist_t                  hist_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  logic [OffsetWidth-1:0] count_i,
  input  logic                   enable_i,
  output match_t                 match_o
);

  logic [WinLen-1:0][7:0] win;
  fmt_e                   pos_fmt [WinLen];
  logic [WinLen-1:0]      pos_ok;

  always_comb begin
    for (int i = 0; i < HistLen; i++) begin
      win[i] = hist_i[HistLen-1-i];
    end
    win[WinLen-1] = byte_i;
  end

  for (genvar J = 0; J < WinLen; J++) begin : g_pos
    logic jpeg_eq;
    logic jp2_eq;
    logic j2k_eq;

    if (J <= WinLen - 3) begin : g_jpeg
      always_comb begin
        jpeg_eq = 1'b1;
        for (int k = 0; k < 3; k++) begin
          jpeg_eq &= (win[J+k] == SigJpeg[k]);
        end
      end
    end else begin : g_no_jpeg
      assign jpeg_eq = 1'b0;
    end

    if (J == 0) begin : g_jp2
      always_comb begin
        jp2_eq = 1'b1;
        for (int k = 0; k < WinLen; k++) begin
          jp2_eq &= (win[k] == SigJp2[k]);
        end
      end
    end else begin : g_no_jp2
      assign jp2_eq = 1'b0;
    end

    if (J <= WinLen - 4) begin : g_j2k
      always_comb begin
        j2k_eq = 1'b1;
        for (int k = 0; k < 4; k++) begin
          j2k_eq &= (win[J+k] == SigJ2k[k]);
        end
      end
    end else begin : g_no_j2k
      assign j2k_eq = 1'b0;
    end

    always_comb begin
      if (jpeg_eq) begin
        pos_fmt[J] = FmtJpeg;
      end else if (jp2_eq || j2k_eq) begin
        pos_fmt[J] = FmtJp2;
      end else begin
        pos_fmt[J] = FmtNone;
      end
    end

    // Full window needs eleven bytes behind it; tail positions only on the
    // last byte and only where the start lies inside the stream.
    if (J == 0) begin : g_full
      assign pos_ok[J] = enable_i && (count_i >= OffsetWidth'(HistLen));
    end else begin : g_tail
      assign pos_ok[J] = enable_i && last_i && (count_i >= OffsetWidth'(HistLen - J));
    end
  end

  always_comb begin
    match_o = '{hit: 1'b0, fmt: FmtNone, offset: '0};
    // Scan downward so the earliest position wins.
    for (int j = WinLen - 1; j >= 0; j--) begin
      if (pos_ok[j] && (pos_fmt[j] != FmtNone)) begin
        match_o.hit    = 1'b1;
        match_o.fmt    = pos_fmt[j];
        match_o.offset = count_i + OffsetWidth'(j) - OffsetWidth'(HistLen);
      end
    end
  end

endmodule

// ===== src/image_signature_scanner.sv =====
// ----------------------------------------------------------------------------
// image_signature_scanner
// Finds the earliest JPEG, JPEG 2000 box or J2K codestream signature in a
// byte stream and reports it once per stream, on its last byte.
// ----------------------------------------------------------------------------
// The scanner takes one byte word per clock cycle, back to back, for as long
// as its result side keeps up. Each byte is registered, compared against all
// three signatures across a 12-byte window in one pass of comparator logic,
// and folded into the stream state as it leaves the input register; when a
// stream's last byte leaves, its result is registered. The result register
// is the only point of back-pressure: a non-last byte is always processed,
// and a last byte waits in the input register only while an earlier result
// is still unclaimed. The offset counter is OffsetWidth bits wide and
// saturates; past that point count_overflow is set and no further offsets
// are examined. No match gives found, image_format and match_offset all zero.
module image_signature_scanner
  import isc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  isc_in_if.sink        in_i,
  isc_out_if.source     out_o
);

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // stream state
  logic [OffsetWidth-1:0] cnt_q, cnt_d;
  logic                   seen_q, seen_d;
  fmt_e                   fmt_q, fmt_d;
  logic [OffsetWidth-1:0] off_q, off_d;
  logic                   ovf_q, ovf_d;

  // result register
  logic                   out_valid_q;
  logic                   res_found_q;
  fmt_e                   res_fmt_q;
  logic [ResOffWidth-1:0] res_off_q;
  logic                   res_ovf_q;

  logic   out_free;
  logic   proc;
  logic   new_hit;
  hist_t  hist;
  match_t match;

  assign out_free  = !out_valid_q || out_o.ready;
  assign proc      = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  isc_history u_history (
    .clk_i  (clk_i),
    .shift_i(proc),
    .byte_i (s1_byte_q),
    .hist_o (hist)
  );

  isc_window_match u_match (
    .hist_i  (hist),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .count_i (cnt_q),
    .enable_i(!ovf_d),
    .match_o (match)
  );

  always_comb begin
    ovf_d   = ovf_q || (cnt_q == CountMax);
    cnt_d   = ovf_d ? cnt_q : cnt_q + OffsetWidth'(1);
    new_hit = !seen_q && match.hit;
    seen_d  = seen_q || match.hit;
    fmt_d   = new_hit ? match.fmt : fmt_q;
    off_d   = new_hit ? match.offset : off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seen_q <= 1'b0;
      fmt_q  <= FmtNone;
      off_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (proc) begin
      if (s1_last_q) begin
        // clear for the next stream
        cnt_q  <= '0;
        seen_q <= 1'b0;
        fmt_q  <= FmtNone;
        off_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        seen_q <= seen_d;
        fmt_q  <= fmt_d;
        off_q  <= off_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && s1_last_q) begin
      res_found_q <= seen_d;
      res_fmt_q   <= seen_d ? fmt_d : FmtNone;
      res_off_q   <= seen_d ? ResOffWidth'(off_d) : '0;
      res_ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = res_found_q;
  assign out_o.image_format   = res_fmt_q;
  assign out_o.match_offset   = res_off_q;
  assign out_o.count_overflow = res_ovf_q;

  // A miss carries no format and no offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.found |-> out_o.image_format == FmtNone && out_o.match_offset == '0)
    else $error("miss result carries format or offset");

  // A hit always names a format.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.found |-> out_o.image_format != FmtNone)
    else $error("hit result without format");

  // Stream state is cleared after the last byte is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_last_q |=> cnt_q == '0 && !seen_q && !ovf_q)
    else $error("stream state not cleared after last byte");

  // Overflow only ever comes with a saturated counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == CountMax)
    else $error("overflow flag set with counter below saturation");

endmodule
